// File: rtl/g2l_pkg.sv
// Package: shared types, constants and the byte-to-character table of the transliterator.
package g2l_pkg;

    // Depth of the job queue between front and back
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    // Input action codes
    localparam logic ACT_BYTE = 1'b0;
    localparam logic ACT_END  = 1'b1;

    // Special input bytes
    localparam logic [7:0] BYTE_UC_MU  = 8'd204;
    localparam logic [7:0] BYTE_LC_MU  = 8'd236;
    localparam logic [7:0] BYTE_UC_NU  = 8'd205;
    localparam logic [7:0] BYTE_LC_NU  = 8'd237;
    localparam logic [7:0] BYTE_LC_PI  = 8'd240;
    localparam logic [7:0] BYTE_UC_PI  = 8'd208;
    localparam logic [7:0] BYTE_UC_TAU = 8'd212;
    localparam logic [7:0] BYTE_LC_TAU = 8'd244;

    // Held-letter state
    typedef enum logic [2:0] {
        PEND_NONE = 3'd0,
        PEND_LM   = 3'd1,
        PEND_UM   = 3'd2,
        PEND_LN   = 3'd3,
        PEND_UN   = 3'd4
    } pend_t;

    // Table entry: up to three characters, ch[0] first
    typedef struct packed {
        logic [1:0]      len;
        logic [2:0][6:0] ch;
    } entry_t;

    // One job: up to four characters for one input transaction
    typedef struct packed {
        logic [2:0]      cnt;
        logic [3:0][6:0] ch;
    } job_t;

    // Front to queue
    typedef struct packed {
        logic valid;
        job_t job;
    } push_t;

    // Queue to back
    typedef struct packed {
        logic valid;
        job_t job;
    } head_t;

    function automatic entry_t ent(input logic [1:0] n, input logic [7:0] a,
                                   input logic [7:0] b, input logic [7:0] c);
        entry_t e;
        e.len   = n;
        e.ch[0] = a[6:0];
        e.ch[1] = b[6:0];
        e.ch[2] = c[6:0];
        return e;
    endfunction

    // Character given for a held letter
    function automatic logic [6:0] held_char(input pend_t p);
        logic [7:0] c;
        unique case (p)
            PEND_LM: c = "m";
            PEND_UM: c = "M";
            PEND_LN: c = "n";
            PEND_UN: c = "N";
            default: c = 8'd0;
        endcase
        return c[6:0];
    endfunction

    // Byte to table entry
    function automatic entry_t map_byte(input logic [7:0] b);
        entry_t e;
        e = ent(2'd0, 8'd0, 8'd0, 8'd0);
        if (!b[7])
        begin
            e = ent((b != 8'd0) ? 2'd1 : 2'd0, b, 8'd0, 8'd0);
        end
        else
        begin
            unique case (b)
                8'd182: e = ent(2'd2, "'", "A", 8'd0);
                8'd184: e = ent(2'd2, "'", "E", 8'd0);
                8'd185: e = ent(2'd2, "'", "H", 8'd0);
                8'd186: e = ent(2'd2, "'", "I", 8'd0);
                8'd188: e = ent(2'd2, "'", "O", 8'd0);
                8'd190: e = ent(2'd2, "'", "Y", 8'd0);
                8'd191: e = ent(2'd2, "'", "W", 8'd0);
                8'd192: e = ent(2'd3, "i", "'", "\"");
                8'd193: e = ent(2'd1, "A", 8'd0, 8'd0);
                8'd194: e = ent(2'd1, "V", 8'd0, 8'd0);
                8'd195: e = ent(2'd1, "G", 8'd0, 8'd0);
                8'd196: e = ent(2'd1, "D", 8'd0, 8'd0);
                8'd197: e = ent(2'd1, "E", 8'd0, 8'd0);
                8'd198: e = ent(2'd1, "Z", 8'd0, 8'd0);
                8'd199: e = ent(2'd1, "H", 8'd0, 8'd0);
                8'd200: e = ent(2'd1, "8", 8'd0, 8'd0);
                8'd201: e = ent(2'd1, "I", 8'd0, 8'd0);
                8'd202: e = ent(2'd1, "K", 8'd0, 8'd0);
                8'd203: e = ent(2'd1, "L", 8'd0, 8'd0);
                8'd204: e = ent(2'd1, "M", 8'd0, 8'd0);
                8'd205: e = ent(2'd1, "N", 8'd0, 8'd0);
                8'd206: e = ent(2'd2, "K", "S", 8'd0);
                8'd207: e = ent(2'd1, "O", 8'd0, 8'd0);
                8'd208: e = ent(2'd1, "P", 8'd0, 8'd0);
                8'd209: e = ent(2'd1, "R", 8'd0, 8'd0);
                8'd211: e = ent(2'd1, "S", 8'd0, 8'd0);
                8'd212: e = ent(2'd1, "T", 8'd0, 8'd0);
                8'd213: e = ent(2'd1, "Y", 8'd0, 8'd0);
                8'd214: e = ent(2'd1, "F", 8'd0, 8'd0);
                8'd215: e = ent(2'd1, "X", 8'd0, 8'd0);
                8'd216: e = ent(2'd2, "P", "S", 8'd0);
                8'd217: e = ent(2'd1, "W", 8'd0, 8'd0);
                8'd218: e = ent(2'd2, "I", "\"", 8'd0);
                8'd219: e = ent(2'd2, "Y", "\"", 8'd0);
                8'd220: e = ent(2'd2, "a", "'", 8'd0);
                8'd221: e = ent(2'd2, "e", "'", 8'd0);
                8'd222: e = ent(2'd2, "h", "'", 8'd0);
                8'd223: e = ent(2'd2, "i", "'", 8'd0);
                8'd224: e = ent(2'd3, "y", "'", "\"");
                8'd225: e = ent(2'd1, "a", 8'd0, 8'd0);
                8'd226: e = ent(2'd1, "v", 8'd0, 8'd0);
                8'd227: e = ent(2'd1, "g", 8'd0, 8'd0);
                8'd228: e = ent(2'd1, "d", 8'd0, 8'd0);
                8'd229: e = ent(2'd1, "e", 8'd0, 8'd0);
                8'd230: e = ent(2'd1, "z", 8'd0, 8'd0);
                8'd231: e = ent(2'd1, "h", 8'd0, 8'd0);
                8'd232: e = ent(2'd1, "8", 8'd0, 8'd0);
                8'd233: e = ent(2'd1, "i", 8'd0, 8'd0);
                8'd234: e = ent(2'd1, "k", 8'd0, 8'd0);
                8'd235: e = ent(2'd1, "l", 8'd0, 8'd0);
                8'd236: e = ent(2'd1, "m", 8'd0, 8'd0);
                8'd237: e = ent(2'd1, "n", 8'd0, 8'd0);
                8'd238: e = ent(2'd2, "k", "s", 8'd0);
                8'd239: e = ent(2'd1, "o", 8'd0, 8'd0);
                8'd240: e = ent(2'd1, "p", 8'd0, 8'd0);
                8'd241: e = ent(2'd1, "r", 8'd0, 8'd0);
                8'd242: e = ent(2'd1, "s", 8'd0, 8'd0);
                8'd243: e = ent(2'd1, "s", 8'd0, 8'd0);
                8'd244: e = ent(2'd1, "t", 8'd0, 8'd0);
                8'd245: e = ent(2'd1, "y", 8'd0, 8'd0);
                8'd246: e = ent(2'd1, "f", 8'd0, 8'd0);
                8'd247: e = ent(2'd1, "x", 8'd0, 8'd0);
                8'd248: e = ent(2'd2, "p", "s", 8'd0);
                8'd249: e = ent(2'd1, "w", 8'd0, 8'd0);
                8'd250: e = ent(2'd2, "i", "\"", 8'd0);
                8'd251: e = ent(2'd2, "y", "\"", 8'd0);
                8'd252: e = ent(2'd2, "o", "'", 8'd0);
                8'd253: e = ent(2'd2, "y", "'", 8'd0);
                8'd254: e = ent(2'd2, "w", "'", 8'd0);
                default: e = ent(2'd0, 8'd0, 8'd0, 8'd0);
            endcase
        end
        return e;
    endfunction

endpackage

// File: rtl/g2l_if.sv
// Interfaces: input byte channel and output character channel.
interface g2l_in_if;
    logic       valid;
    logic       ready;
    logic       action;
    logic [7:0] in_byte;

    modport source (output valid, output action, output in_byte, input ready);
    modport sink   (input valid, input action, input in_byte, output ready);
endinterface

interface g2l_out_if;
    logic       valid;
    logic       ready;
    logic [6:0] out_char;
    logic       last;

    modport source (output valid, output out_char, output last, input ready);
    modport sink   (input valid, input out_char, input last, output ready);
endinterface

// File: rtl/g2l_front.sv
// Front end: accepts bytes, tracks the held letter and builds character jobs.
module g2l_front (
    input  logic               clk,
    input  logic               rst_n,
    g2l_in_if.sink             in_ch,
    input  logic               q_ready,
    output g2l_pkg::push_t     push
);

    g2l_pkg::pend_t  pend_reg;
    g2l_pkg::pend_t  pend_next;
    g2l_pkg::entry_t ent;
    g2l_pkg::job_t   job;
    logic            fire;
    logic            is_pi;
    logic            is_tau;
    g2l_pkg::pend_t  hold;

    assign in_ch.ready = q_ready;
    assign fire        = in_ch.valid && in_ch.ready;

    // Held-letter state register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            pend_reg <= g2l_pkg::PEND_NONE;
        else if (fire)
            pend_reg <= pend_next;
    end

    // Classification of the byte
    always_comb
    begin
        ent    = g2l_pkg::map_byte(in_ch.in_byte);
        is_pi  = (in_ch.in_byte == g2l_pkg::BYTE_LC_PI) ||
                 (in_ch.in_byte == g2l_pkg::BYTE_UC_PI);
        is_tau = (in_ch.in_byte == g2l_pkg::BYTE_LC_TAU) ||
                 (in_ch.in_byte == g2l_pkg::BYTE_UC_TAU);
        unique case (in_ch.in_byte)
            g2l_pkg::BYTE_LC_MU: hold = g2l_pkg::PEND_LM;
            g2l_pkg::BYTE_UC_MU: hold = g2l_pkg::PEND_UM;
            g2l_pkg::BYTE_LC_NU: hold = g2l_pkg::PEND_LN;
            g2l_pkg::BYTE_UC_NU: hold = g2l_pkg::PEND_UN;
            default:             hold = g2l_pkg::PEND_NONE;
        endcase
    end

    // Next state and job contents
    always_comb
    begin
        pend_next = g2l_pkg::PEND_NONE;
        job.cnt   = 3'd0;
        job.ch[0] = g2l_pkg::held_char(pend_reg);
        job.ch[1] = ent.ch[0];
        job.ch[2] = ent.ch[1];
        job.ch[3] = ent.ch[2];
        if (in_ch.action == g2l_pkg::ACT_END)
        begin
            job.cnt = (pend_reg == g2l_pkg::PEND_NONE) ? 3'd0 : 3'd1;
        end
        else
        begin
            unique case (pend_reg)
                g2l_pkg::PEND_LM, g2l_pkg::PEND_UM, g2l_pkg::PEND_LN, g2l_pkg::PEND_UN:
                begin
                    if (hold != g2l_pkg::PEND_NONE)
                    begin
                        job.cnt   = 3'd1;
                        pend_next = hold;
                    end
                    else if ((pend_reg == g2l_pkg::PEND_LM ||
                              pend_reg == g2l_pkg::PEND_UM) && is_pi)
                    begin
                        job.cnt = 3'd1;
                        job.ch[0] = (pend_reg == g2l_pkg::PEND_LM) ? 7'h62 : 7'h42;
                    end
                    else if ((pend_reg == g2l_pkg::PEND_LN ||
                              pend_reg == g2l_pkg::PEND_UN) && is_tau)
                    begin
                        job.cnt = 3'd1;
                        job.ch[0] = (pend_reg == g2l_pkg::PEND_LN) ? 7'h64 : 7'h44;
                    end
                    else
                    begin
                        job.cnt = 3'd1 + {1'b0, ent.len};
                    end
                end
                default:
                begin
                    // nothing held: the byte is held or gives its own entry
                    if (hold != g2l_pkg::PEND_NONE)
                    begin
                        pend_next = hold;
                    end
                    else
                    begin
                        job.cnt   = {1'b0, ent.len};
                        job.ch[0] = ent.ch[0];
                        job.ch[1] = ent.ch[1];
                        job.ch[2] = ent.ch[2];
                    end
                end
            endcase
        end
    end

    // Empty jobs are not queued
    assign push.valid = fire && (job.cnt != 3'd0);
    assign push.job   = job;

endmodule

// File: rtl/g2l_queue.sv
// Job queue: a short FIFO of character jobs between front and back.
module g2l_queue (
    input  logic               clk,
    input  logic               rst_n,
    input  g2l_pkg::push_t     push,
    output logic               q_ready,
    output g2l_pkg::head_t     head,
    input  logic               pop
);

    g2l_pkg::job_t                     mem_reg [g2l_pkg::QUEUE_DEPTH];
    logic [g2l_pkg::QPTR_W-1:0]        wr_reg;
    logic [g2l_pkg::QPTR_W-1:0]        rd_reg;
    logic [g2l_pkg::QCNT_W-1:0]        cnt_reg;
    logic [g2l_pkg::QPTR_W-1:0]        wr_next;
    logic [g2l_pkg::QPTR_W-1:0]        rd_next;
    logic [g2l_pkg::QCNT_W-1:0]        cnt_next;
    logic                              do_push;
    logic                              do_pop;

    assign q_ready    = (cnt_reg != g2l_pkg::QCNT_W'(g2l_pkg::QUEUE_DEPTH));
    assign do_push    = push.valid && q_ready;
    assign do_pop     = pop && head.valid;
    assign head.valid = (cnt_reg != '0);
    assign head.job   = mem_reg[rd_reg];

    // Pointer and count update
    always_comb
    begin
        wr_next  = wr_reg;
        rd_next  = rd_reg;
        cnt_next = cnt_reg;
        if (do_push)
            wr_next = (wr_reg == g2l_pkg::QPTR_W'(g2l_pkg::QUEUE_DEPTH - 1)) ? '0
                      : wr_reg + 1'b1;
        if (do_pop)
            rd_next = (rd_reg == g2l_pkg::QPTR_W'(g2l_pkg::QUEUE_DEPTH - 1)) ? '0
                      : rd_reg + 1'b1;
        if (do_push && !do_pop)
            cnt_next = cnt_reg + 1'b1;
        else if (!do_push && do_pop)
            cnt_next = cnt_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg  <= '0;
            rd_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            wr_reg  <= wr_next;
            rd_reg  <= rd_next;
            cnt_reg <= cnt_next;
        end
    end

    // Job storage
    always_ff @(posedge clk)
    begin
        if (do_push)
            mem_reg[wr_reg] <= push.job;
    end

endmodule

// File: rtl/g2l_back.sv
// Back end: sends the characters of the head job one per cycle while the output is ready.
module g2l_back (
    input  logic               clk,
    input  logic               rst_n,
    input  g2l_pkg::head_t     head,
    output logic               pop,
    g2l_out_if.source          out_ch
);

    logic [1:0] idx_reg;
    logic [1:0] idx_next;
    logic       fire;
    logic       is_last;

    assign is_last         = ({1'b0, idx_reg} == (head.job.cnt - 3'd1));
    assign out_ch.valid    = head.valid;
    assign out_ch.out_char = head.job.ch[idx_reg];
    assign out_ch.last     = is_last;
    assign fire            = out_ch.valid && out_ch.ready;
    assign pop             = fire && is_last;

    // Character index within the job
    always_comb
    begin
        idx_next = idx_reg;
        if (fire)
            idx_next = is_last ? 2'd0 : idx_reg + 2'd1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            idx_reg <= 2'd0;
        else
            idx_reg <= idx_next;
    end

endmodule

// File: rtl/greek_to_latin_transliterator.sv
// Top level: ISO 8859-7 to ASCII transliterator, front end, job queue and back end.
// The jobs built from accepted bytes are registered in the job queue and offered from its head.
// Throughput: one character per cycle on the output while out_ch.ready is high; a byte
//   gives at most 4 characters, sent one after another through the single output port.
// The front accepts a new byte every cycle while the two-entry job queue has room.
// Reset (rst_n low, asynchronous) clears the held letter and empties the queue.
module greek_to_latin_transliterator (
    input  logic        clk,
    input  logic        rst_n,
    g2l_in_if.sink      in_ch,
    g2l_out_if.source   out_ch
);

    g2l_pkg::push_t push;
    g2l_pkg::head_t head;
    logic           q_ready;
    logic           pop;

    g2l_front u_front (
        .clk     (clk),
        .rst_n   (rst_n),
        .in_ch   (in_ch),
        .q_ready (q_ready),
        .push    (push)
    );

    g2l_queue u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (push),
        .q_ready (q_ready),
        .head    (head),
        .pop     (pop)
    );

    g2l_back u_back (
        .clk     (clk),
        .rst_n   (rst_n),
        .head    (head),
        .pop     (pop),
        .out_ch  (out_ch)
    );

endmodule
